// ===== rtl/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, codes and the sigmoid table of the network inference engine.
// ----------------------------------------------------------------------------
package mlp_pkg;

  // item codes
  localparam logic [1:0] LD_NORM    = 2'd0;
  localparam logic [1:0] LD_WEIGHT  = 2'd1;
  localparam logic [1:0] LD_BIAS    = 2'd2;
  localparam logic [1:0] LD_FEATURE = 2'd3;

  // activation codes
  localparam logic [1:0] AF_RELU    = 2'd0;
  localparam logic [1:0] AF_SIGMOID = 2'd1;
  localparam logic [1:0] AF_TANH    = 2'd2;
  localparam logic [1:0] AF_SIG_ALT = 2'd3;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_WIDTH = 2'd2;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748380;

  typedef enum logic [2:0] {
    REG_NUM_LAYERS = 3'd0,
    REG_INPUT_DIM  = 3'd1,
    REG_LAYER0     = 3'd2,
    REG_LAYER1     = 3'd3,
    REG_LAYER2     = 3'd4,
    REG_LAYER3     = 3'd5,
    REG_ACT_CODES  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_COL,
    S_ROW,
    S_DRAIN,
    S_ACT,
    S_NEXT,
    S_FINAL,
    S_FREAD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        address;
    logic signed [31:0] value;
    logic signed [31:0] scale;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] probability;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic init;
    logic op_valid;
  } mac_ctl_t;

  typedef struct packed {
    logic       bypass;
    logic [1:0] code;
  } act_ctl_t;

  typedef logic [31:0] sig_table_t [256];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid((i-128)/16) from integer exponentials
  function automatic sig_table_t build_sig_table();
    logic [63:0] e [129];
    logic [95:0] p;
    logic [63:0] d;
    logic [63:0] nn;
    int          kk;
    sig_table_t  t;
    e[0] = 64'h1_0000_0000;
    for (int k = 0; k < 128; k++) begin
      p = 96'(e[k]) * 96'(EXP_STEP_Q32) + (96'd1 << 31);
      e[k+1] = 64'(p >> 32);
    end
    for (int i = 0; i < 256; i++) begin
      kk = (i >= 128) ? i - 128 : 128 - i;
      d  = 64'h1_0000_0000 + e[kk];
      nn = (i >= 128) ? (64'd1 << 48) : (e[kk] << 16);
      t[i] = 32'(udiv64(nn + (d >> 1), d));
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/mlp_mac.sv =====
// ----------------------------------------------------------------------------
// mlp_mac
// Shared multiply-accumulate unit: registered product, 64-bit accumulator,
// saturated 32-bit view of the sum.
// ----------------------------------------------------------------------------
module mlp_mac (
  input  logic                clk,
  input  logic                rst,
  input  mlp_pkg::mac_ctl_t   ctl,
  input  logic signed [63:0]  init_val,
  input  logic signed [32:0]  op_a,
  input  logic signed [31:0]  op_b,
  output logic signed [31:0]  sat_out
);
  import mlp_pkg::*;

  logic signed [64:0] prod_q;
  logic               prod_v;
  logic signed [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.op_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= 65'(op_a) * 65'(op_b);
    if (ctl.init) begin
      acc <= init_val;
    end else if (prod_v) begin
      acc <= acc + 64'(prod_q >>> 16);
    end
  end

  always_comb begin
    if (acc > 64'sh7FFF_FFFF) begin
      sat_out = 32'sh7FFF_FFFF;
    end else if (acc < -64'sh8000_0000) begin
      sat_out = -32'sh8000_0000;
    end else begin
      sat_out = 32'(acc);
    end
  end

endmodule

// ===== rtl/mlp_act.sv =====
// ----------------------------------------------------------------------------
// mlp_act
// Activation stage: relu, table sigmoid and tanh, or pass-through.
// ----------------------------------------------------------------------------
module mlp_act (
  input  mlp_pkg::act_ctl_t  ctl,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);
  import mlp_pkg::*;

  logic signed [33:0] arg;
  logic signed [34:0] t;
  logic [7:0]         idx;
  logic [31:0]        sig;

  always_comb begin
    arg = (ctl.code == AF_TANH) ? (34'(x) <<< 1) : 34'(x);
    t   = 35'(arg) + 35'sd524288;
    if (t < 0) begin
      idx = 8'd0;
    end else if ((t >>> 12) > 35'sd255) begin
      idx = 8'd255;
    end else begin
      idx = 8'(t >>> 12);
    end
    sig = SIG_TABLE[idx];
  end

  always_comb begin
    if (ctl.bypass) begin
      y = x;
    end else begin
      case (ctl.code)
        AF_RELU: y = (x < 0) ? 32'sd0 : x;
        AF_TANH: y = 32'((33'(sig) << 1) - 33'd65536);
        default: y = signed'(sig);
      endcase
    end
  end

endmodule

// ===== rtl/mlp_inference_engine_core.sv =====
// ----------------------------------------------------------------------------
// mlp_inference_engine_core
// Fully connected network forward pass in Q16.16 on one shared multiplier.
// ----------------------------------------------------------------------------
// Load items (norm pair, weight, bias) and features without last are taken
// whenever the block is idle. A feature marked last starts the network run;
// the block then deasserts item_ready until the result is staged. The run is
// bound by the single multiply-accumulate unit, one product per cycle while a
// column's rows issue; the normalization pass and each layer run column by
// column, each column passing through S_COL, S_ROW, S_DRAIN and S_ACT. A count
// mismatch goes from S_CHECK straight to S_RESULT.
// Weight and bias depths are powers of two; addresses wrap by truncation.
// Result sits in an output register, so loads continue while it waits.
module mlp_inference_engine_core #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_LAYERS   = 4,
  parameter int WEIGHT_DEPTH = 4096,
  parameter int BIAS_DEPTH   = 512
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  mlp_pkg::item_t    item,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output mlp_pkg::result_t  result,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mlp_pkg::*;

  localparam int IW  = $clog2(MAX_WIDTH);
  localparam int WAW = $clog2(WEIGHT_DEPTH);
  localparam int BAW = $clog2(BIAS_DEPTH);

  // configuration registers
  logic [2:0] num_layers;
  logic [7:0] input_dim;
  logic [7:0] layer_width [4];
  logic [7:0] act_codes;
  reg_idx_t   widx;
  reg_idx_t   ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers <= 3'd1;
      input_dim  <= 8'd1;
      for (int i = 0; i < 4; i++) begin
        layer_width[i] <= 8'd1;
      end
      act_codes  <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_NUM_LAYERS: num_layers     <= pwdata[2:0];
        REG_INPUT_DIM:  input_dim      <= pwdata[7:0];
        REG_LAYER0:     layer_width[0] <= pwdata[7:0];
        REG_LAYER1:     layer_width[1] <= pwdata[7:0];
        REG_LAYER2:     layer_width[2] <= pwdata[7:0];
        REG_LAYER3:     layer_width[3] <= pwdata[7:0];
        REG_ACT_CODES:  act_codes      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_NUM_LAYERS: prdata = 32'(num_layers);
      REG_INPUT_DIM:  prdata = 32'(input_dim);
      REG_LAYER0:     prdata = 32'(layer_width[0]);
      REG_LAYER1:     prdata = 32'(layer_width[1]);
      REG_LAYER2:     prdata = 32'(layer_width[2]);
      REG_LAYER3:     prdata = 32'(layer_width[3]);
      REG_ACT_CODES:  prdata = 32'(act_codes);
      default:        prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t         state;
  state_t         state_next;
  logic [7:0]     feature_count;
  logic           norm_mode;      // normalization pass runs as one-product columns
  logic [2:0]     lyr;
  logic [7:0]     cur_in;
  logic [7:0]     out_dim;
  logic [7:0]     rows;
  logic [7:0]     row;
  logic [7:0]     col;
  logic [1:0]     drain;
  logic           src_bank;
  logic [WAW-1:0] base;
  logic [WAW-1:0] wptr;
  logic signed [31:0] res_prob;
  logic [1:0]     res_status;

  // effective layer count and widths
  logic [2:0] nl_eff;
  logic [7:0] next_width;
  logic [2:0] next_lyr;
  logic       count_bad;

  assign nl_eff   = (32'(num_layers) > MAX_LAYERS) ? 3'(MAX_LAYERS) : num_layers;
  assign next_lyr = norm_mode ? 3'd0 : lyr + 3'd1;
  always_comb begin
    next_width = layer_width[next_lyr[1:0]];
    if (32'(next_width) > MAX_WIDTH) begin
      next_width = 8'(MAX_WIDTH);
    end
  end
  assign count_bad = (32'(input_dim) > MAX_WIDTH) || (feature_count != input_dim);

  // memories and pipeline
  logic signed [31:0] weight_mem [WEIGHT_DEPTH];
  logic signed [31:0] bias_mem   [BIAS_DEPTH];
  logic signed [31:0] mean_mem   [MAX_WIDTH];
  logic signed [31:0] inv_mem    [MAX_WIDTH];
  logic signed [31:0] buf_mem    [2*MAX_WIDTH];   // both activation banks

  logic signed [31:0] weight_q, bias_q, mean_q, inv_q, buf_q;
  logic [IW:0]        buf_raddr;
  logic [IW:0]        buf_waddr;
  logic signed [31:0] buf_wdata;
  logic               buf_we;
  logic [BAW-1:0]     bias_raddr;
  logic               accept;
  logic               issue;
  logic               v1;
  logic               bias_v;
  mac_ctl_t           mac_ctl;
  act_ctl_t           act_ctl;
  logic signed [32:0] op_a;
  logic signed [31:0] op_b;
  logic signed [31:0] mac_sat;
  logic signed [31:0] act_y;

  assign accept = item_valid && item_ready;

  // loads write straight from the item
  always_ff @(posedge clk) begin
    if (accept && item.action == LD_WEIGHT) begin
      weight_mem[WAW'(item.address)] <= item.value;
    end
    weight_q <= weight_mem[wptr];
  end

  always_ff @(posedge clk) begin
    if (accept && item.action == LD_BIAS) begin
      bias_mem[BAW'(item.address)] <= item.value;
    end
    bias_q <= bias_mem[bias_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && item.action == LD_NORM) begin
      mean_mem[IW'(item.address)] <= item.value;
      inv_mem[IW'(item.address)]  <= item.scale;
    end
    mean_q <= mean_mem[IW'(col)];
    inv_q  <= inv_mem[IW'(col)];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_q <= buf_mem[buf_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.action == LD_FEATURE && item.last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = count_bad ? S_RESULT : S_COL;
      S_COL:    state_next = (col == out_dim) ? S_NEXT : S_ROW;
      S_ROW: begin
        if (9'(row) + 9'd1 >= 9'(rows)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = (drain == 2'd1) ? S_ACT : S_DRAIN;
      S_ACT:    state_next = S_COL;
      S_NEXT:   state_next = (next_lyr == nl_eff) ? S_FINAL : S_COL;
      S_FINAL:  state_next = (cur_in != 8'd1) ? S_RESULT : S_FREAD;
      S_FREAD:  state_next = S_RESULT;
      S_RESULT: state_next = (!result_valid || result_ready) ? S_IDLE : S_RESULT;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = (state == S_IDLE);
    issue      = (state == S_ROW) && (row < rows);
    bias_raddr = BAW'(32'(lyr) * MAX_WIDTH + 32'(col));
    buf_raddr  = {src_bank, IW'(row)};
    if (state == S_FINAL) begin
      buf_raddr = {src_bank, {IW{1'b0}}};
    end else if (norm_mode) begin
      buf_raddr = {1'b0, IW'(col)};
    end
    buf_we    = 1'b0;
    buf_waddr = {1'b0, IW'(feature_count)};
    buf_wdata = item.value;
    if (state == S_ACT) begin
      buf_we    = 1'b1;
      buf_waddr = {norm_mode ? 1'b0 : ~src_bank, IW'(col)};
      buf_wdata = act_y;
    end else if (accept && item.action == LD_FEATURE &&
                 32'(feature_count) < MAX_WIDTH) begin
      buf_we = 1'b1;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      feature_count <= 8'd0;
      result_valid  <= 1'b0;
      v1            <= 1'b0;
      bias_v        <= 1'b0;
    end else begin
      state  <= state_next;
      v1     <= issue;
      bias_v <= (state == S_COL) && (col != out_dim);
      if (accept && item.action == LD_FEATURE && feature_count != 8'd255) begin
        feature_count <= feature_count + 8'd1;
      end
      if (state == S_CHECK) begin
        feature_count <= 8'd0;
      end
      if (state == S_RESULT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_CHECK: begin
        // normalization: one product per feature, written back in place
        norm_mode  <= 1'b1;
        lyr        <= 3'd0;
        cur_in     <= input_dim;
        out_dim    <= input_dim;
        rows       <= 8'd1;
        col        <= 8'd0;
        src_bank   <= 1'b0;
        base       <= '0;
        res_prob   <= 32'sd0;
        res_status <= ST_COUNT;
      end
      S_COL: begin
        row   <= 8'd0;
        drain <= 2'd0;
        wptr  <= base + WAW'(col);
      end
      S_ROW: begin
        if (issue) begin
          row  <= row + 8'd1;
          wptr <= wptr + WAW'(out_dim);
        end
      end
      S_DRAIN: drain <= drain + 2'd1;
      S_ACT:   col <= col + 8'd1;
      S_NEXT: begin
        if (!norm_mode) begin
          cur_in   <= out_dim;
          src_bank <= ~src_bank;
          base     <= base + WAW'(16'(cur_in) * 16'(out_dim));
          rows     <= out_dim;
        end else begin
          rows     <= cur_in;
        end
        norm_mode <= 1'b0;
        lyr       <= next_lyr;
        out_dim   <= next_width;
        col       <= 8'd0;
      end
      S_FINAL: begin
        res_prob   <= 32'sd0;
        res_status <= ST_WIDTH;
      end
      S_FREAD: begin
        res_prob   <= buf_q;
        res_status <= ST_OK;
      end
      S_RESULT: begin
        if (!result_valid || result_ready) begin
          result.probability <= res_prob;
          result.status      <= res_status;
        end
      end
      default: ;
    endcase
  end

  // shared multiply-accumulate
  always_comb begin
    mac_ctl.init     = bias_v;
    mac_ctl.op_valid = v1;
    op_a = norm_mode ? (33'(buf_q) - 33'(mean_q)) : 33'(buf_q);
    op_b = norm_mode ? inv_q : weight_q;
    act_ctl.bypass = norm_mode;
    act_ctl.code   = 2'(act_codes >> {lyr[1:0], 1'b0});
  end

  mlp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .init_val (norm_mode ? 64'sd0 : 64'(bias_q)),
    .op_a     (op_a),
    .op_b     (op_b),
    .sat_out  (mac_sat)
  );

  mlp_act u_act (
    .ctl (act_ctl),
    .x   (mac_sat),
    .y   (act_y)
  );

  // checks
  a_last_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == LD_FEATURE && item.last) |=> (state == S_CHECK))
    else $error("closing feature did not start a run");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_COUNT ||
                      result.status == ST_WIDTH))
    else $error("result status out of range");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) |-> (col < out_dim))
    else $error("activation write past layer width");

endmodule

// ===== test/mlp_inference_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// mlp_inference_engine_core_tb
// Self-checking testbench of the network inference engine.
// ----------------------------------------------------------------------------
// Loads weights, biases and normalization pairs, then streams feature vectors
// under a series of register settings. Each accepted transaction goes through
// a local fixed-point forward-pass predictor, and every result is compared
// field by field with the oldest pending prediction. Both handshake sides
// idle at random. Stores are only ever read at entries that were loaded.
// ----------------------------------------------------------------------------
module mlp_inference_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlp_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mlp_inference_engine_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // pending transactions and predicted network outputs
  item_t   pending_items[$];
  result_t predicted_outputs[$];

  // predictor copy of the register file and the stores
  int unsigned        reg_val [7];
  logic signed [31:0] wt_mem [4096];
  logic signed [31:0] bias_mem [512];
  logic signed [31:0] mean_mem [128];
  logic signed [31:0] istd_mem [128];
  logic signed [31:0] feat_buf [128];
  int unsigned        feat_count;
  logic [31:0]        logistic_lut [256];

  // which store entries the stimulus has loaded so far
  bit w_loaded [4096];
  bit b_loaded [512];
  bit n_loaded [128];

  int  err_count;
  int  items_queued;
  int  items_accepted;
  int  results_checked;
  int  phase_count;
  bit  no_idle;
  int  send_gap;
  int  recv_stall;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sigmoid table over [-8,8) in steps of 1/16, built from integer exponentials
  function automatic void fill_logistic_lut();
    longint unsigned ex [129];
    longint unsigned den;
    longint unsigned num;
    int              steps;
    ex[0] = 64'h1_0000_0000;
    for (int k = 0; k < 128; k++)
      ex[k+1] = (ex[k] * 64'd4034748380 + (64'd1 << 31)) >> 32;
    for (int i = 0; i < 256; i++) begin
      steps = (i >= 128) ? i - 128 : 128 - i;
      den  = 64'h1_0000_0000 + ex[steps];
      num  = (i >= 128) ? (64'd1 << 48) : (ex[steps] << 16);
      logistic_lut[i] = 32'((num + den / 2) / den);
    end
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] logistic(logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + (64'sd8 <<< 16);
    if (t < 0) return logistic_lut[0];
    t = t >>> 12;
    if (t > 255) t = 255;
    return logistic_lut[t];
  endfunction

  function automatic logic signed [31:0] activation(logic signed [31:0] a, logic [1:0] code);
    logic signed [63:0] wide;
    wide = a;
    case (code)
      AF_RELU: return (a < 0) ? 32'sd0 : a;
      AF_TANH: begin
        wide = 2 * 64'(logistic(2 * wide)) - 65536;
        return wide[31:0];
      end
      default: return logistic(wide);
    endcase
  endfunction

  // forward pass over the buffered features
  function automatic result_t forward_pass();
    logic signed [31:0] src [128];
    logic signed [31:0] dst [128];
    logic signed [63:0] acc;
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    int unsigned        nl;
    int unsigned        in_dim;
    int unsigned        out_dim;
    int unsigned        base;
    logic [1:0]         code;
    result_t            r;
    r.probability = '0;
    in_dim = reg_val[REG_INPUT_DIM];
    if (in_dim > 128 || feat_count != in_dim) begin
      r.status = ST_COUNT;
      return r;
    end
    for (int k = 0; k < in_dim; k++) begin
      lhs = feat_buf[k];
      lhs = lhs - mean_mem[k];
      rhs = istd_mem[k];
      src[k] = sat32((lhs * rhs) >>> 16);
    end
    nl = (reg_val[REG_NUM_LAYERS] > 4) ? 4 : reg_val[REG_NUM_LAYERS];
    base = 0;
    for (int k = 0; k < nl; k++) begin
      out_dim = (reg_val[REG_LAYER0 + k] > 128) ? 128 : reg_val[REG_LAYER0 + k];
      code = 2'(reg_val[REG_ACT_CODES] >> (2 * k));
      for (int col = 0; col < out_dim; col++) begin
        acc = bias_mem[(k * 128 + col) % 512];
        for (int row = 0; row < in_dim; row++) begin
          lhs = src[row];
          rhs = wt_mem[(base + row * out_dim + col) % 4096];
          acc = acc + ((lhs * rhs) >>> 16);
        end
        dst[col] = activation(sat32(acc), code);
      end
      base = base + in_dim * out_dim;
      in_dim = out_dim;
      src = dst;
    end
    if (in_dim != 1) begin
      r.status = ST_WIDTH;
      return r;
    end
    r.status = ST_OK;
    r.probability = src[0];
    return r;
  endfunction

  // update predictor state with one accepted transaction
  function automatic void absorb_item(item_t it);
    case (it.action)
      LD_NORM: begin
        mean_mem[it.address % 128] = it.value;
        istd_mem[it.address % 128] = it.scale;
      end
      LD_WEIGHT: wt_mem[it.address] = it.value;
      LD_BIAS:   bias_mem[it.address % 512] = it.value;
      default: begin
        if (feat_count < 128) feat_buf[feat_count] = it.value;
        if (feat_count < 255) feat_count++;
        if (it.last) begin
          predicted_outputs = {predicted_outputs, forward_pass()};
          feat_count = 0;
        end
      end
    endcase
  endfunction

  // wait count for one transaction on either side
  function automatic int draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return 0;
  endfunction

  // q16.16 value: mostly small, sometimes full range or an extreme
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h0;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // driver: presents pending transactions and predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      send_gap <= 0;
    end else begin
      if (item_valid && item_ready) begin
        absorb_item(item);
        items_accepted++;
      end
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          send_gap <= draw_wait();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: accepts results with random stalls and checks them
  always @(posedge clk) begin
    result_t exp_r;
    int      n;
    if (rst) begin
      result_ready <= 1'b0;
      recv_stall <= 0;
    end else if (result_valid && result_ready) begin
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result prob=%h status=%0d", $time,
                 result.probability, result.status);
        err_count++;
      end else begin
        exp_r = predicted_outputs.pop_front();
        if (result.probability !== exp_r.probability) begin
          $display("%0t: probability mismatch expected %h actual %h", $time,
                   exp_r.probability, result.probability);
          err_count++;
        end
        if (result.status !== exp_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_r.status, result.status);
          err_count++;
        end
        results_checked++;
      end
      n = draw_wait();
      recv_stall <= n;
      result_ready <= (n == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      result_ready <= (recv_stall == 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic push_item(logic [1:0] act, logic [11:0] addr, logic [31:0] val,
                           logic [31:0] scl, logic lst);
    item_t it;
    it.action = act;
    it.address = addr;
    it.value = val;
    it.scale = scl;
    it.last = lst;
    pending_items = {pending_items, it};
    items_queued++;
    case (act)
      LD_NORM:   n_loaded[addr % 128] = 1'b1;
      LD_WEIGHT: w_loaded[addr] = 1'b1;
      LD_BIAS:   b_loaded[addr % 512] = 1'b1;
      default: ;
    endcase
  endtask

  // when n_feat matches the input width and fits the buffer, loads every entry the next
  // inference reads that is still empty, plus a few random reloads; then streams n_feat features
  task automatic queue_inference(int n_feat);
    int unsigned in_dim;
    int unsigned out_dim;
    int unsigned nl;
    int unsigned base;
    int unsigned a;
    in_dim = reg_val[REG_INPUT_DIM];
    if (in_dim <= 128 && n_feat == in_dim) begin
      for (int k = 0; k < in_dim; k++)
        if (!n_loaded[k] || $urandom_range(0, 15) == 0)
          push_item(LD_NORM, 12'(k + 128 * $urandom_range(0, 31)), rand_q(), rand_q(), 1'b0);
      nl = (reg_val[REG_NUM_LAYERS] > 4) ? 4 : reg_val[REG_NUM_LAYERS];
      base = 0;
      for (int k = 0; k < nl; k++) begin
        out_dim = (reg_val[REG_LAYER0 + k] > 128) ? 128 : reg_val[REG_LAYER0 + k];
        for (int col = 0; col < out_dim; col++) begin
          a = (k * 128 + col) % 512;
          if (!b_loaded[a] || $urandom_range(0, 15) == 0)
            push_item(LD_BIAS, 12'(a + 512 * $urandom_range(0, 7)), rand_q(), $urandom,
                      $urandom_range(0, 1));
          for (int row = 0; row < in_dim; row++) begin
            a = (base + row * out_dim + col) % 4096;
            if (!w_loaded[a] || $urandom_range(0, 15) == 0)
              push_item(LD_WEIGHT, 12'(a), rand_q(), $urandom, $urandom_range(0, 1));
          end
        end
        base = base + in_dim * out_dim;
        in_dim = out_dim;
      end
    end
    for (int i = 0; i < n_feat; i++)
      push_item(LD_FEATURE, 12'($urandom), rand_q(), $urandom, i == n_feat - 1);
  endtask

  // apb write: setup then access cycle
  task automatic write_reg(reg_idx_t idx, int unsigned val);
    logic [31:0] data;
    data = {$urandom_range(0, 1) ? 24'($urandom) : 24'd0, 8'(val)};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_val[idx] = (idx == REG_NUM_LAYERS) ? (data & 32'h7) : (data & 32'hFF);
  endtask

  // only called when the block is idle
  task automatic set_network(int unsigned nl, int unsigned in_dim, int unsigned w0,
                             int unsigned w1, int unsigned w2, int unsigned w3,
                             int unsigned codes);
    write_reg(REG_NUM_LAYERS, nl);
    write_reg(REG_INPUT_DIM, in_dim);
    write_reg(REG_LAYER0, w0);
    write_reg(REG_LAYER1, w1);
    write_reg(REG_LAYER2, w2);
    write_reg(REG_LAYER3, w3);
    write_reg(REG_ACT_CODES, codes);
    phase_count++;
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // hold off until every queued transaction is accepted and every result is through
  task automatic wait_idle();
    while (items_accepted < items_queued || predicted_outputs.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int unsigned nl;
    int unsigned in_dim;
    int unsigned w [4];
    int          n_feat;
    int          last_layer;
    err_count = 0;
    items_queued = 0;
    items_accepted = 0;
    results_checked = 0;
    phase_count = 0;
    no_idle = 1'b0;
    feat_count = 0;
    reg_val = '{1, 1, 1, 1, 1, 1, 0};
    fill_logistic_lut();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one relu neuron on one feature, extreme field values
    push_item(LD_NORM, 12'hF80, 32'h0, 32'h0001_0000, 1'b1);
    push_item(LD_WEIGHT, 12'h000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
    push_item(LD_BIAS, 12'hE00, 32'h0, 32'h0, 1'b0);
    push_item(LD_FEATURE, 12'hFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_item(LD_FEATURE, 12'h000, 32'h8000_0000, 32'h0, 1'b1);
    push_item(LD_NORM, 12'h07F, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_item(LD_FEATURE, 12'h000, 32'h7FFF_FFFF, 32'h0, 1'b1);
    push_item(LD_NORM, 12'h000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_item(LD_WEIGHT, 12'h000, 32'h8000_0000, 32'h0, 1'b0);
    push_item(LD_BIAS, 12'h000, 32'h8000_0000, 32'h0, 1'b0);
    push_item(LD_FEATURE, 12'h555, 32'h8000_0000, 32'h0, 1'b1);
    // count mismatch: two features against one expected
    queue_inference(2);
    queue_inference(1);
    wait_idle();

    // no layers: normalized feature is the output; then final width three
    set_network(0, 1, 1, 1, 1, 1, 0);
    queue_inference(1);
    wait_idle();
    set_network(0, 3, 1, 1, 1, 1, 0);
    queue_inference(3);
    wait_idle();

    // layer count clamped to four, an empty layer, all sigmoid fallback
    set_network(7, 3, 2, 0, 3, 1, 255);
    queue_inference(3);
    queue_inference(3);
    wait_idle();

    // count checks: zero, above the buffer, and a count that saturates
    set_network(1, 0, 1, 1, 1, 1, AF_TANH);
    queue_inference(1);
    wait_idle();
    set_network(1, 200, 1, 1, 1, 1, 0);
    queue_inference(130);
    wait_idle();
    set_network(1, 44, 1, 1, 1, 1, 0);
    queue_inference(260);
    wait_idle();

    // width above the buffer is clamped, final width not one
    set_network(1, 2, 255, 1, 1, 1, AF_SIGMOID);
    queue_inference(2);
    wait_idle();

    // tanh on the output layer
    set_network(2, 4, 3, 1, 1, 1, {AF_TANH, AF_RELU});
    queue_inference(4);
    queue_inference(4);
    wait_idle();

    // four layers deep, every activation, run once
    set_network(4, 6, 6, 6, 6, 1, {AF_SIGMOID, AF_TANH, AF_SIG_ALT, AF_RELU});
    queue_inference(6);
    wait_idle();

    // random settings, small sizes
    while (items_queued < 1250) begin
      nl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      in_dim = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      for (int k = 0; k < 4; k++)
        case ($urandom_range(0, 9))
          0: w[k] = 0;
          1: w[k] = $urandom_range(7, 16);
          default: w[k] = $urandom_range(1, 6);
        endcase
      last_layer = (nl > 4) ? 3 : int'(nl) - 1;
      if (last_layer >= 0 && $urandom_range(0, 6) != 0) w[last_layer] = 1;
      set_network(nl, in_dim, w[0], w[1], w[2], w[3], $urandom_range(0, 255));
      repeat ($urandom_range(3, 8)) begin
        n_feat = in_dim;
        if ($urandom_range(0, 9) == 0)
          n_feat = (in_dim > 1 && $urandom_range(0, 1)) ? in_dim - 1 : in_dim + 1;
        // some load noise at random addresses
        repeat ($urandom_range(0, 3))
          push_item(2'($urandom_range(0, 2)), 12'($urandom), rand_q(), rand_q(),
                    $urandom_range(0, 1));
        queue_inference(n_feat);
      end
      wait_idle();
    end

    $display("covered %0d transactions and %0d checked results over %0d register settings",
             items_accepted, results_checked, phase_count);
    $display("including empty, clamped and oversized layers, count errors and all activations");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
